// ===== design/isb_pkg.sv =====
// shared types and constants for the indexed sequence buffer
package isb_pkg;

  localparam int CAPACITY = 32;
  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_ERASE  = 2'd1,
    FN_DUMP   = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DUMP
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic dump_next;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic dump_multi;
    logic dump_last;
  } dp_stat_t;

endpackage

// ===== design/isb_ctrl.sv =====
// controller state machine for the indexed sequence buffer
module isb_ctrl import isb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = stat.dump_multi ? S_DUMP : S_IDLE;
        end
      end
      S_DUMP: begin
        if (stat.out_free) begin
          cmd.dump_next = 1'b1;
          if (stat.dump_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== design/isb_dp.sv =====
// datapath: command registers, entry store with parallel shift, result register
module isb_dp import isb_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dp_cmd_t                 cmd,
  output dp_stat_t                stat,
  input  logic [1:0]              in_func,
  input  logic [POS_W-1:0]        in_position,
  input  logic signed [VAL_W-1:0] in_item_value,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic [POS_W-1:0]        out_entry_count,
  output logic                    out_has_entry,
  output logic signed [VAL_W-1:0] out_entry_out,
  output logic                    out_last
);

  logic [1:0]              func_r;
  logic [POS_W-1:0]        pos_r;
  logic [VAL_W-1:0]        val_r;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [IDX_W-1:0]        idx_r;
  logic [VAL_W-1:0]        entries_r   [CAPACITY];
  logic [VAL_W-1:0]        entries_nxt [CAPACITY];
  logic [POS_W-1:0]        cnt_ext;
  logic [1:0]              op_status;
  logic                    out_valid_r;
  logic [1:0]              status_r;
  logic [CNT_W-1:0]        ocount_r;
  logic                    has_r;
  logic [VAL_W-1:0]        eout_r;
  logic                    last_r;

  assign cnt_ext = POS_W'(count_r);

  // status and store update for the captured command
  always_comb begin
    op_status = ST_OK;
    count_nxt = count_r;
    for (int i = 0; i < CAPACITY; i++) entries_nxt[i] = entries_r[i];
    case (func_r)
      FN_INSERT: begin
        if (pos_r > cnt_ext) begin
          op_status = ST_RANGE;
        end else if (count_r == CNT_W'(CAPACITY)) begin
          op_status = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
          for (int i = 0; i < CAPACITY; i++) begin
            if (POS_W'(i) == pos_r) begin
              entries_nxt[i] = val_r;
            end else if (i > 0 && POS_W'(i) > pos_r && POS_W'(i) <= cnt_ext) begin
              entries_nxt[i] = entries_r[(i > 0) ? i - 1 : 0];
            end
          end
        end
      end
      FN_ERASE: begin
        if (pos_r >= cnt_ext) begin
          op_status = ST_RANGE;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          for (int i = 0; i < CAPACITY - 1; i++) begin
            if (POS_W'(i) >= pos_r && POS_W'(i + 1) < cnt_ext) begin
              entries_nxt[i] = entries_r[i + 1];
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign stat.out_free   = !out_valid_r || out_ready;
  assign stat.dump_multi = (func_r == FN_DUMP) && (count_r > CNT_W'(1));
  assign stat.dump_last  = (CNT_W'(idx_r) + CNT_W'(1)) == count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec) count_r <= count_nxt;
      if (cmd.exec || cmd.dump_next) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      pos_r  <= in_position;
      val_r  <= in_item_value;
    end
    if (cmd.exec) begin
      for (int i = 0; i < CAPACITY; i++) entries_r[i] <= entries_nxt[i];
      status_r <= op_status;
      ocount_r <= count_nxt;
      idx_r    <= IDX_W'(1);
      if (func_r == FN_DUMP && count_r != '0) begin
        has_r  <= 1'b1;
        eout_r <= entries_r[0];
        last_r <= (count_r == CNT_W'(1));
      end else begin
        has_r  <= 1'b0;
        eout_r <= '0;
        last_r <= 1'b1;
      end
    end else if (cmd.dump_next) begin
      status_r <= ST_OK;
      ocount_r <= count_r;
      has_r    <= 1'b1;
      eout_r   <= entries_r[idx_r];
      last_r   <= stat.dump_last;
      idx_r    <= idx_r + IDX_W'(1);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_entry_count = POS_W'(ocount_r);
  assign out_has_entry   = has_r;
  assign out_entry_out   = eout_r;
  assign out_last        = last_r;

endmodule

// ===== design/indexed_sequence_buffer_unit.sv =====
// top level of the indexed sequence buffer: controller plus datapath
//
// holds an ordered list of up to CAPACITY signed 32-bit values
// input channel (in_valid/in_ready): in_func selects insert, erase or dump,
// in_position gives the list position, in_item_value the value to insert
// result channel (out_valid/out_ready): status, entry count after the
// command, has_entry/entry_out for dumped values and last on the final
// result of each input transaction
// insert, erase and unused codes give one result; a dump gives one result
// per stored entry (or one empty-marked result when the list is empty)
// a transaction is captured into the command registers in the idle state,
// and its first result is registered in the execute state once the result
// register is free; a dump then sends one entry per cycle, while the receiver
// is ready, from the result register, the only path out of the store
// insert and erase shift all later entries in parallel
// when the receiver stalls, the result register holds and the controller
// waits; a new command is taken while the last result still waits
// reset (rst_n low, synchronous) empties the list and drops any result
module indexed_sequence_buffer_unit import isb_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_func,
  input  logic [POS_W-1:0]        in_position,
  input  logic signed [VAL_W-1:0] in_item_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_status,
  output logic [POS_W-1:0]        out_entry_count,
  output logic                    out_has_entry,
  output logic signed [VAL_W-1:0] out_entry_out,
  output logic                    out_last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencing: idle -> execute -> (dump walk) -> idle
  isb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // store, count and result register
  isb_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_func         (in_func),
    .in_position     (in_position),
    .in_item_value   (in_item_value),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .out_has_entry   (out_has_entry),
    .out_entry_out   (out_entry_out),
    .out_last        (out_last)
  );

  // one command at a time: after a transaction the controller is busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a command is in flight");

  // count never exceeds the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entry_count <= POS_W'(CAPACITY)))
    else $error("entry count above capacity");

  // error results are single, final and carry no entry
  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_last && !out_has_entry))
    else $error("error result not final or carries an entry");

  // dumped entries always report ok
  a_dump_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_has_entry) |-> (out_status == ST_OK && out_entry_count != '0))
    else $error("dumped entry with bad status or empty count");

endmodule

// ===== tb/tb_indexed_sequence_buffer_unit.sv =====
// testbench for the indexed sequence buffer: queued command driver, self-checking result monitor
module tb_indexed_sequence_buffer_unit;
  import isb_pkg::*;

  // code 3 is not an operation; the block answers it with a plain ok
  localparam logic [1:0] FN_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER = 25;
  localparam int QUIET_TAIL = 20;

  typedef struct {
    logic [1:0]              fn;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
  } command_t;

  typedef struct {
    status_t                 status;
    logic [POS_W-1:0]        count;
    logic                    has_entry;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } list_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              in_func = FN_DUMP;
  logic [POS_W-1:0]        in_position = '0;
  logic signed [VAL_W-1:0] in_item_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [1:0]              out_status;
  logic [POS_W-1:0]        out_entry_count;
  logic                    out_has_entry;
  logic signed [VAL_W-1:0] out_entry_out;
  logic                    out_last;

  indexed_sequence_buffer_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_position     (in_position),
    .in_item_value   (in_item_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .out_has_entry   (out_has_entry),
    .out_entry_out   (out_entry_out),
    .out_last        (out_last)
  );

  always #6 clk = ~clk;

  // commands waiting to be offered, and results predicted but not yet seen
  command_t     pending_cmds[$];
  list_result_t expected_results[$];

  // shadow copy of the list, updated when a command transaction is accepted
  logic signed [VAL_W-1:0] list_mem [CAPACITY];
  int unsigned             list_len = 0;

  // list length as the stimulus builder expects it to be (count only)
  int unsigned plan_len = 0;

  int errors = 0;
  int cmds_accepted = 0;
  int results_seen = 0;
  int entries_dumped = 0;
  int full_seen = 0;
  int range_seen = 0;
  int cycle_count = 0;

  // long receiver hold-off, and the quiet tail with no idling
  int   hold_left = 0;
  int   hold_seen_cmds = 0;
  logic hold_done = 1'b0;
  logic quiet = 1'b0;

  task automatic report_mismatch(input string msg);
    errors++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic push_result(input status_t st, input logic has, input logic signed [VAL_W-1:0] v,
                             input logic lst);
    list_result_t r;
    r.status    = st;
    r.count     = list_len[POS_W-1:0];
    r.has_entry = has;
    r.value     = v;
    r.last      = lst;
    expected_results.insert(expected_results.size(), r);
  endtask

  // apply one command to the shadow list and queue the results it causes
  task automatic apply_list_command(input command_t c);
    int unsigned p;
    int          i;
    status_t     st;
    p  = c.pos;
    st = ST_OK;
    case (c.fn)
      FN_INSERT: begin
        // the position check wins over the full check
        if (p > list_len) begin
          st = ST_RANGE;
        end else if (list_len >= CAPACITY) begin
          st = ST_FULL;
        end else begin
          for (i = list_len; i > p; i--) list_mem[i] = list_mem[i-1];
          list_mem[p] = c.val;
          list_len++;
        end
        push_result(st, 1'b0, '0, 1'b1);
      end
      FN_ERASE: begin
        if (p >= list_len) begin
          st = ST_RANGE;
        end else begin
          for (i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
        push_result(st, 1'b0, '0, 1'b1);
      end
      FN_DUMP: begin
        if (list_len == 0) begin
          push_result(ST_OK, 1'b0, '0, 1'b1);
        end else begin
          for (i = 0; i < list_len; i++) push_result(ST_OK, 1'b1, list_mem[i], i + 1 == list_len);
        end
      end
      default: begin
        push_result(ST_OK, 1'b0, '0, 1'b1);
      end
    endcase
  endtask

  // stimulus building: tracks the planned list length so sequences stay meaningful
  task automatic queue_cmd(input logic [1:0] fn, input int unsigned pos,
                           input logic signed [VAL_W-1:0] val);
    command_t c;
    c.fn  = fn;
    c.pos = pos[POS_W-1:0];
    c.val = val;
    pending_cmds.insert(pending_cmds.size(), c);
    if (fn == FN_INSERT && pos <= plan_len && plan_len < CAPACITY) plan_len++;
    else if (fn == FN_ERASE && pos < plan_len) plan_len--;
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned pick_insert_pos();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return plan_len;  // append at the end
      default: return $urandom_range(0, plan_len);
    endcase
  endfunction

  task automatic build_stimulus();
    int k;
    // directed: empty list corners
    queue_cmd(FN_DUMP, 0, '0);
    queue_cmd(FN_ERASE, 0, '0);
    queue_cmd(FN_INSERT, 1, 32'sd5);
    queue_cmd(FN_INSERT, 127, -32'sd1);
    // build a short list with the value extremes, front, back and middle inserts
    queue_cmd(FN_INSERT, 0, 32'sh7fff_ffff);
    queue_cmd(FN_INSERT, 0, 32'sh8000_0000);
    queue_cmd(FN_INSERT, 2, -32'sd1);
    queue_cmd(FN_INSERT, 1, '0);
    queue_cmd(FN_INSERT, 64, 32'sd9);
    queue_cmd(FN_DUMP, 127, 32'sh5a5a_a5a5);
    // erase one past the end, then the last and the first entries
    queue_cmd(FN_ERASE, 4, '0);
    queue_cmd(FN_ERASE, 3, '0);
    queue_cmd(FN_ERASE, 0, '0);
    queue_cmd(FN_UNUSED, 127, -32'sd1);
    queue_cmd(FN_DUMP, 0, '0);
    queue_cmd(FN_ERASE, 1, '0);
    queue_cmd(FN_ERASE, 0, '0);
    queue_cmd(FN_ERASE, 0, '0);
    queue_cmd(FN_DUMP, 0, '0);

    // fill to capacity, then hit the full and the range-before-full cases
    while (plan_len < CAPACITY) queue_cmd(FN_INSERT, pick_insert_pos(), pick_value());
    queue_cmd(FN_INSERT, $urandom_range(0, CAPACITY), pick_value());
    queue_cmd(FN_INSERT, CAPACITY + 1, pick_value());
    queue_cmd(FN_DUMP, 0, '0);

    // mixed traffic, mostly legal commands with random content
    repeat (25) begin
      k = $urandom_range(0, 19);
      if (k < 8) begin
        queue_cmd(FN_INSERT, pick_insert_pos(), pick_value());
      end else if (k < 15) begin
        queue_cmd(FN_ERASE, (plan_len == 0) ? 0 : $urandom_range(0, plan_len - 1), pick_value());
      end else if (k < 17) begin
        queue_cmd(FN_DUMP, $urandom_range(0, 127), pick_value());
      end else if (k < 19) begin
        if ($urandom_range(0, 1) == 0) queue_cmd(FN_INSERT, $urandom_range(plan_len + 1, 127),
                                                 pick_value());
        else queue_cmd(FN_ERASE, $urandom_range(plan_len, 127), pick_value());
      end else begin
        queue_cmd(FN_UNUSED, $urandom_range(0, 127), pick_value());
      end
    end

    // drain the list at random positions and finish on an empty dump
    while (plan_len > 0) queue_cmd(FN_ERASE, $urandom_range(0, plan_len - 1), pick_value());
    queue_cmd(FN_DUMP, 0, '0);
  endtask

  // driver: offers queued commands, holds them until accepted, idles in bursts
  always @(posedge clk) begin
    logic take;
    int   gap_left;
    command_t c;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      take = in_valid && in_ready;
      if (take) begin
        // predict from the payload that was just accepted
        c.fn  = in_func;
        c.pos = in_position;
        c.val = in_item_value;
        apply_list_command(c);
        cmds_accepted++;
        if (pending_cmds.size() >= QUIET_TAIL && hold_left == 0 && $urandom_range(0, 3) == 0)
          gap_left = $urandom_range(1, 11);
      end
      quiet <= (pending_cmds.size() < QUIET_TAIL);
      if (!(in_valid && !take)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          c = pending_cmds.pop_front();
          in_valid      <= 1'b1;
          in_func       <= c.fn;
          in_position   <= c.pos;
          in_item_value <= c.val;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off, started after some commands went through
  // so the result register backs up and the block stops taking commands
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left      <= 0;
      hold_seen_cmds <= 0;
      hold_done      <= 1'b0;
    end else begin
      if (in_valid && in_ready) hold_seen_cmds <= hold_seen_cmds + 1;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (!hold_done && hold_seen_cmds >= HOLD_AFTER) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end
    end
  end

  // monitor: checks each result transaction against the oldest prediction
  always @(posedge clk) begin
    list_result_t e;
    int           stall_left;
    logic         ready_next;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected (status %0d count %0d)",
                                    out_status, out_entry_count));
        end else begin
          e = expected_results.pop_front();
          if (out_status !== e.status)
            report_mismatch($sformatf("status %0d, want %0d", out_status, e.status));
          if (out_entry_count !== e.count)
            report_mismatch($sformatf("entry_count %0d, want %0d", out_entry_count, e.count));
          if (out_has_entry !== e.has_entry)
            report_mismatch($sformatf("has_entry %0b, want %0b", out_has_entry, e.has_entry));
          if (out_entry_out !== e.value)
            report_mismatch($sformatf("entry_out %0d, want %0d", out_entry_out, e.value));
          if (out_last !== e.last)
            report_mismatch($sformatf("last %0b, want %0b", out_last, e.last));
          if (e.has_entry) entries_dumped++;
          if (e.status == ST_FULL) full_seen++;
          if (e.status == ST_RANGE) range_seen++;
        end
      end
      // receiver idling: long hold, random stall bursts, none in the tail
      if (hold_left != 0) begin
        ready_next = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 10);
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
      end
      out_ready <= ready_next;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_count,
               expected_results.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    build_stimulus();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // wait for every command to go in and every predicted result to come out
    while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0) @(posedge clk);
    // stray results after the last one would show up here
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("ran %0d list commands, checked %0d results including %0d dumped entries",
             cmds_accepted, results_seen, entries_dumped);
    $display("saw %0d full-store and %0d bad-position answers, %0d mismatches",
             full_seen, range_seen, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/isb_pkg.sv
design/isb_ctrl.sv
design/isb_dp.sv
design/indexed_sequence_buffer_unit.sv
tb/tb_indexed_sequence_buffer_unit.sv
